/* hw/rtl/sdsch_pkg.sv */
// ----------------------------------------------------------------------------
// sdsch_pkg: shared types and constants of the SCAN disk scheduler
// Sizes, register indexes and the control words of the cell chains.
// ----------------------------------------------------------------------------
package sdsch_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_BITS     = 16;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int SUM_W        = 17;
  localparam int DC_W         = CYL_BITS + 1;
  localparam int ADD_W        = ((CYL_BITS > SUM_W) ? CYL_BITS : SUM_W) + 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_DISK_CYLINDERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP       = 2'd2;

  typedef logic [CYL_BITS-1:0] cyl_t;

  typedef enum logic [1:0] {
    SORT_HOLD,
    SORT_INSERT,
    SORT_SHIFT_DOWN,
    SORT_SHIFT_UP
  } sort_op_t;

  typedef struct packed {
    sort_op_t op;
    cyl_t     data;
  } sort_ctl_t;

  typedef enum logic [1:0] {
    STACK_HOLD,
    STACK_PUSH,
    STACK_POP
  } stack_op_t;

endpackage

/* hw/rtl/sdsch_sort_cell.sv */
// ----------------------------------------------------------------------------
// sdsch_sort_cell: one cell of the sorted request chain
// Holds one request; inserts in ascending order and shifts either way.
// ----------------------------------------------------------------------------
module sdsch_sort_cell import sdsch_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sort_ctl_t ctl,
  input  cyl_t      lo_val,
  input  logic      lo_valid,
  input  logic      lo_greater,
  input  cyl_t      hi_val,
  input  logic      hi_valid,
  output cyl_t      val,
  output logic      valid,
  output logic      greater
);

  // an empty cell counts as greater than any request
  assign greater = !valid || (val > ctl.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        SORT_INSERT: begin
          if (greater) begin
            if (lo_greater) begin
              val   <= lo_val;
              valid <= lo_valid;
            end else begin
              val   <= ctl.data;
              valid <= 1'b1;
            end
          end
        end
        SORT_SHIFT_DOWN: begin
          val   <= hi_val;
          valid <= hi_valid;
        end
        SORT_SHIFT_UP: begin
          val   <= lo_val;
          valid <= lo_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/sdsch_stack_cell.sv */
// ----------------------------------------------------------------------------
// sdsch_stack_cell: one cell of the deferred request stack
// Takes its lower neighbour on a push and its upper neighbour on a pop.
// ----------------------------------------------------------------------------
module sdsch_stack_cell import sdsch_pkg::*; (
  input  logic      clk,
  input  stack_op_t op,
  input  cyl_t      lo_val,
  input  cyl_t      hi_val,
  output cyl_t      val
);

  always_ff @(posedge clk) begin
    case (op)
      STACK_PUSH: val <= lo_val;
      STACK_POP:  val <= hi_val;
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/scan_disk_scheduler.sv */
// ----------------------------------------------------------------------------
// scan_disk_scheduler: SCAN (elevator) disk request scheduler
// Collects a batch of cylinder requests and serves them in elevator order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on cylinder/last_request, one item per cycle, taken at a
//   clock edge with start high and busy low. Each request is slotted into a
//   sorted chain of cells as it arrives, so collection runs at one item per
//   cycle; items past MAX_REQUESTS are dropped, but a marked last item still
//   closes the batch. Write the configuration registers (cfg_we, cfg_index,
//   cfg_data) only while no batch is being served.
//   After the last item busy rises and the chain drains: from the low end
//   when sweeping up, one request a cycle, and from the high end when
//   sweeping down, where the empty cells above the requests shift out
//   first. Requests on the far side of the start head go onto a stack of
//   cells, which is popped after the turn at the disk edge (S_TURN). Each
//   popped request is registered in pick_val, then in the result register.
//   Each result is shown for one cycle with strobe high; the receiver
//   cannot stall. The closing item, in the first cycle after busy falls,
//   carries the total movement with is_total and end_of_run set. Reset
//   empties both chains and returns to idle.
// ----------------------------------------------------------------------------
module scan_disk_scheduler import sdsch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cyl_t                 cylinder,
  input  logic                 last_request,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DC_W-1:0]      cfg_data,
  output logic                 strobe,
  output cyl_t                 served_cylinder,
  output logic [SUM_W-1:0]     total_movement,
  output logic                 is_total,
  output logic                 end_of_run
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SORT_POP = 5'b00010,
    S_TURN     = 5'b00100,
    S_STACK_POP = 5'b01000,
    S_TOTAL    = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [DC_W-1:0] disk_cylinders;
  cyl_t            start_head;
  logic            sweep_up;

  // batch context
  logic [CNT_W-1:0] request_count;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] stack_count;
  cyl_t             edge_cyl;
  cyl_t             h0;
  logic             dir_up;
  cyl_t             head;
  logic [SUM_W-1:0] sum;
  cyl_t             pick_val;
  logic             pick_valid;

  // cell chains
  sort_ctl_t sort_ctl;
  stack_op_t stack_op;
  cyl_t      sort_val   [MAX_REQUESTS];
  logic      sort_valid [MAX_REQUESTS];
  logic      sort_gt    [MAX_REQUESTS];
  cyl_t      stack_val  [MAX_REQUESTS];

  logic             accept;
  logic             insert;
  logic [CNT_W-1:0] count_ins;
  logic [DC_W-1:0]  dc_minus;
  cyl_t             edge_c;
  cyl_t             h0_c;
  logic             popped;
  cyl_t             pop_raw;
  cyl_t             pop_sat;
  logic             pick_emit;
  logic             pick_push;
  logic             travel_en;
  cyl_t             tgt;
  cyl_t             travel;
  logic [ADD_W-1:0] sum_wide;
  logic [SUM_W-1:0] sum_next;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign insert    = accept && (request_count < CNT_W'(MAX_REQUESTS));
  assign count_ins = insert ? (request_count + CNT_W'(1)) : request_count;

  // highest cylinder: zero size acts as one cylinder, oversize clips
  assign dc_minus = disk_cylinders - DC_W'(1);
  always_comb begin
    if (disk_cylinders == '0) begin
      edge_c = '0;
    end else if (disk_cylinders[CYL_BITS]) begin
      edge_c = '1;
    end else begin
      edge_c = dc_minus[CYL_BITS-1:0];
    end
  end
  assign h0_c = (start_head > edge_c) ? edge_c : start_head;

  // chain control: insert while collecting, drain while sorting out
  always_comb begin
    sort_ctl.data = cylinder;
    sort_ctl.op   = SORT_HOLD;
    popped        = 1'b0;
    pop_raw       = sort_val[0];
    if (insert) begin
      sort_ctl.op = SORT_INSERT;
    end else if (state == S_SORT_POP && remain != '0) begin
      if (dir_up) begin
        sort_ctl.op = SORT_SHIFT_DOWN;
        popped      = sort_valid[0];
        pop_raw     = sort_val[0];
      end else begin
        sort_ctl.op = SORT_SHIFT_UP;
        popped      = sort_valid[MAX_REQUESTS-1];
        pop_raw     = sort_val[MAX_REQUESTS-1];
      end
    end
  end
  assign pop_sat = (pop_raw > edge_cyl) ? edge_cyl : pop_raw;

  // serve a picked request now, or defer it to the return sweep
  always_comb begin
    if (state == S_STACK_POP) begin
      pick_emit = pick_valid;
    end else if (dir_up) begin
      pick_emit = pick_valid && (pick_val >= h0);
    end else begin
      pick_emit = pick_valid && (pick_val <= h0);
    end
  end
  assign pick_push = pick_valid && !pick_emit;

  always_comb begin
    if (pick_push) begin
      stack_op = STACK_PUSH;
    end else if (state == S_STACK_POP && stack_count != '0) begin
      stack_op = STACK_POP;
    end else begin
      stack_op = STACK_HOLD;
    end
  end

  // head travel, saturating total
  assign travel_en = pick_emit || (state == S_TURN);
  always_comb begin
    if (state == S_TURN) begin
      tgt = dir_up ? edge_cyl : '0;
    end else begin
      tgt = pick_val;
    end
  end
  assign travel   = (tgt >= head) ? (tgt - head) : (head - tgt);
  assign sum_wide = ADD_W'(sum) + ADD_W'(travel);
  assign sum_next = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];

  // cell rows
  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cells
    cyl_t lo_v;
    logic lo_ok;
    logic lo_g;
    cyl_t hi_v;
    logic hi_ok;
    cyl_t st_lo;
    cyl_t st_hi;

    if (i == 0) begin : g_low
      assign lo_v  = '0;
      assign lo_ok = 1'b0;
      assign lo_g  = 1'b0;
      assign st_lo = pick_val;
    end else begin : g_mid
      assign lo_v  = sort_val[i-1];
      assign lo_ok = sort_valid[i-1];
      assign lo_g  = sort_gt[i-1];
      assign st_lo = stack_val[i-1];
    end

    if (i == MAX_REQUESTS - 1) begin : g_top
      assign hi_v  = '0;
      assign hi_ok = 1'b0;
      assign st_hi = '0;
    end else begin : g_below
      assign hi_v  = sort_val[i+1];
      assign hi_ok = sort_valid[i+1];
      assign st_hi = stack_val[i+1];
    end

    sdsch_sort_cell u_sort (
      .clk        (clk),
      .rst        (rst),
      .ctl        (sort_ctl),
      .lo_val     (lo_v),
      .lo_valid   (lo_ok),
      .lo_greater (lo_g),
      .hi_val     (hi_v),
      .hi_valid   (hi_ok),
      .val        (sort_val[i]),
      .valid      (sort_valid[i]),
      .greater    (sort_gt[i])
    );

    sdsch_stack_cell u_stack (
      .clk    (clk),
      .op     (stack_op),
      .lo_val (st_lo),
      .hi_val (st_hi),
      .val    (stack_val[i])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_cylinders <= DC_W'(200);
      start_head     <= '0;
      sweep_up       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISK_CYLINDERS: disk_cylinders <= cfg_data;
        REG_START_HEAD:     start_head     <= cfg_data[CYL_BITS-1:0];
        REG_SWEEP_UP:       sweep_up       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      request_count <= '0;
      remain        <= '0;
      stack_count   <= '0;
      pick_valid    <= 1'b0;
    end else begin
      pick_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_request) begin
              // close the batch: start the drain; the sweep and head are latched below
              request_count <= '0;
              remain        <= count_ins;
              state         <= S_SORT_POP;
            end else begin
              request_count <= count_ins;
            end
          end
        end
        S_SORT_POP: begin
          pick_valid <= popped;
          if (popped) begin
            remain <= remain - CNT_W'(1);
          end
          if (pick_push) begin
            stack_count <= stack_count + CNT_W'(1);
          end
          if (remain == '0 && !pick_valid) begin
            state <= S_TURN;
          end
        end
        S_TURN: begin
          state <= S_STACK_POP;
        end
        S_STACK_POP: begin
          if (stack_count != '0) begin
            pick_valid  <= 1'b1;
            stack_count <= stack_count - CNT_W'(1);
          end else if (!pick_valid) begin
            state <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // batch context and picked request
  always_ff @(posedge clk) begin
    if (accept && last_request) begin
      edge_cyl <= edge_c;
      h0       <= h0_c;
      dir_up   <= sweep_up;
      head     <= h0_c;
      sum      <= '0;
    end else if (travel_en) begin
      head <= tgt;
      sum  <= sum_next;
    end
    if (state == S_STACK_POP) begin
      pick_val <= stack_val[0];
    end else begin
      pick_val <= pop_sat;
    end
  end

  // result register: one item per served request, then the total
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= pick_emit || (state == S_TOTAL);
    end
    if (state == S_TOTAL) begin
      served_cylinder <= '0;
      total_movement  <= sum;
      is_total        <= 1'b1;
      end_of_run      <= 1'b1;
    end else begin
      served_cylinder <= pick_val;
      total_movement  <= '0;
      is_total        <= 1'b0;
      end_of_run      <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_total_closes : assert property (@(posedge clk) disable iff (rst)
    strobe && is_total |=> !strobe)
    else $error("result after the closing total item");

  a_served_busy : assert property (@(posedge clk) disable iff (rst)
    strobe && !is_total |-> busy)
    else $error("served item outside a batch");

  a_pick_busy : assert property (@(posedge clk) disable iff (rst)
    pick_valid |-> (state == S_SORT_POP || state == S_STACK_POP))
    else $error("picked request outside the serving states");

  a_stack_bound : assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(MAX_REQUESTS))
    else $error("deferred stack overflow");

  a_drained : assert property (@(posedge clk) disable iff (rst)
    state == S_TOTAL |-> (remain == '0 && stack_count == '0))
    else $error("total issued with requests still pending");
`endif

endmodule

/* sim/scan_disk_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// scan_disk_scheduler_tb: self-checking bench of the SCAN disk scheduler
// Drives request batches from a directed table and then at random, across
// several disk sizes, start heads and sweep directions. Every accepted item
// feeds a model of the elevator schedule in the bench. Every strobed result
// is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_tb;
  import sdsch_pkg::*;

  localparam int RAND_ITEMS  = 350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_GAP  = 8;    // cycles left after busy falls before a write
  localparam int N_DIR       = 29;

  // One result item as the block presents it
  typedef struct packed {
    cyl_t             cyl;
    logic [SUM_W-1:0] total;
    logic             is_total;
    logic             end_of_run;
  } serve_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // A directed row: a request or a register write. Rows marked typed carry
  // the served cylinder and the total of a one-request batch.
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DC_W-1:0]      value;
    logic                 last;
    logic                 typed;
    cyl_t                 exp_cyl;
    logic [SUM_W-1:0]     exp_total;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  cyl_t                 cylinder;
  logic                 last_request;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DC_W-1:0]      cfg_data;
  logic                 strobe;
  cyl_t                 served_cylinder;
  logic [SUM_W-1:0]     total_movement;
  logic                 is_total;
  logic                 end_of_run;

  // Bench copy of the registers and of the block's state
  logic [DC_W-1:0]  disk_cyl;
  cyl_t             head_cfg;
  logic             sweep_up;
  cyl_t             req_store [MAX_REQUESTS];
  int unsigned      req_cnt;
  int unsigned      head_pos;
  int unsigned      move_sum;

  serve_t           serve_queue [$];
  int               fails;
  int               items_sent;

  // Typed expectation of the item now on the request ports
  logic             typed_on;
  cyl_t             typed_cyl;
  logic [SUM_W-1:0] typed_total;

  row_t dir_rows [N_DIR] = '{
    // reset settings: 200 cylinders, head 0, sweeping up
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd50,     1'b1, 1'b1, 16'd50,    17'd199},
    // request beyond the edge, served at the edge
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd65535,  1'b1, 1'b1, 16'd199,   17'd199},
    // equal requests
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd10,     1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd10,     1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd5,      1'b1, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_START_HEAD,     17'd100,    1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_SWEEP_UP,       17'd0,      1'b0, 1'b0, 16'd0,     17'd0},
    // nothing below the head: travel to cylinder 0 all the same
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd150,    1'b1, 1'b1, 16'd150,   17'd250},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd0,      1'b1, 1'b1, 16'd0,     17'd100},
    // both sides of the head, one request on it
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd30,     1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd100,    1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd180,    1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd120,    1'b1, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_SWEEP_UP,       17'd1,      1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd150,    1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd40,     1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd100,    1'b1, 1'b0, 16'd0,     17'd0},
    // zero disk size acts as one cylinder; head beyond the edge saturates
    '{ROW_CFG, REG_DISK_CYLINDERS, 17'd0,      1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_START_HEAD,     17'd65535,  1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd65535,  1'b1, 1'b1, 16'd0,     17'd0},
    // full-size disk, head on the top cylinder
    '{ROW_CFG, REG_DISK_CYLINDERS, 17'h10000,  1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd0,      1'b1, 1'b1, 16'd0,     17'd65535},
    // disk size above the cylinder range is clamped
    '{ROW_CFG, REG_DISK_CYLINDERS, 17'h1FFFF,  1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_START_HEAD,     17'd0,      1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd65535,  1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd0,      1'b1, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_SWEEP_UP,       17'd0,      1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_CFG, REG_START_HEAD,     17'd65535,  1'b0, 1'b0, 16'd0,     17'd0},
    '{ROW_REQ, REG_DISK_CYLINDERS, 17'd65535,  1'b1, 1'b1, 16'd65535, 17'd65535}
  };

  scan_disk_scheduler u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cylinder        (cylinder),
    .last_request    (last_request),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .strobe          (strobe),
    .served_cylinder (served_cylinder),
    .total_movement  (total_movement),
    .is_total        (is_total),
    .end_of_run      (end_of_run)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Highest cylinder for the current disk size, with both clamps applied
  function automatic int unsigned top_cylinder();
    int unsigned n;
    n = disk_cyl;
    if (n == 0) n = 1;
    if (n > (1 << CYL_BITS)) n = 1 << CYL_BITS;
    return n - 1;
  endfunction

  // Move the head, adding the travel to the total with saturation
  function automatic void travel_to_cyl(int unsigned to);
    int unsigned d;
    d = (to >= head_pos) ? (to - head_pos) : (head_pos - to);
    move_sum = (move_sum + d > SUM_MAX) ? SUM_MAX : move_sum + d;
    head_pos = to;
  endfunction

  // Sort the batch and queue its results in elevator order, total last
  function automatic void plan_scan_order();
    int unsigned sorted [MAX_REQUESTS];
    int unsigned top_cyl, h0, x, j;
    top_cyl  = top_cylinder();
    h0       = (head_cfg > top_cyl) ? top_cyl : head_cfg;
    head_pos = h0;
    move_sum = 0;
    for (int i = 0; i < req_cnt; i++) begin
      x = (req_store[i] > top_cyl) ? top_cyl : req_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > x) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = x;
    end
    if (sweep_up) begin
      for (int i = 0; i < req_cnt; i++) begin
        if (sorted[i] >= h0) begin
          travel_to_cyl(sorted[i]);
          serve_queue.push_back(serve_t'{cyl_t'(sorted[i]), '0, 1'b0, 1'b0});
        end
      end
      travel_to_cyl(top_cyl);
      for (int i = req_cnt - 1; i >= 0; i--) begin
        if (sorted[i] < h0) begin
          travel_to_cyl(sorted[i]);
          serve_queue.push_back(serve_t'{cyl_t'(sorted[i]), '0, 1'b0, 1'b0});
        end
      end
    end else begin
      for (int i = req_cnt - 1; i >= 0; i--) begin
        if (sorted[i] <= h0) begin
          travel_to_cyl(sorted[i]);
          serve_queue.push_back(serve_t'{cyl_t'(sorted[i]), '0, 1'b0, 1'b0});
        end
      end
      travel_to_cyl(0);
      for (int i = 0; i < req_cnt; i++) begin
        if (sorted[i] > h0) begin
          travel_to_cyl(sorted[i]);
          serve_queue.push_back(serve_t'{cyl_t'(sorted[i]), '0, 1'b0, 1'b0});
        end
      end
    end
    serve_queue.push_back(serve_t'{'0, move_sum[SUM_W-1:0], 1'b1, 1'b1});
  endfunction

  // Take accepted items into the batch and check every strobed result
  always @(posedge clk) begin
    serve_t want;
    if (!rst) begin
      if (start && !busy) begin
        if (req_cnt < MAX_REQUESTS) begin
          req_store[req_cnt] = cylinder;
          req_cnt++;
        end
        if (last_request) begin
          if (typed_on) begin
            serve_queue.push_back(serve_t'{typed_cyl, '0, 1'b0, 1'b0});
            serve_queue.push_back(serve_t'{'0, typed_total, 1'b1, 1'b1});
          end else begin
            plan_scan_order();
          end
          req_cnt = 0;
        end
      end
      if (strobe) begin
        if (serve_queue.size() == 0) begin
          $error("result with none expected: served_cylinder %0d total_movement %0d",
                 served_cylinder, total_movement);
          fails++;
        end else begin
          want = serve_queue.pop_front();
          if (served_cylinder !== want.cyl) begin
            $error("served_cylinder: expected %0d, actual %0d", want.cyl, served_cylinder);
            fails++;
          end
          if (total_movement !== want.total) begin
            $error("total_movement: expected %0d, actual %0d", want.total, total_movement);
            fails++;
          end
          if (is_total !== want.is_total) begin
            $error("is_total: expected %0d, actual %0d", want.is_total, is_total);
            fails++;
          end
          if (end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0d, actual %0d", want.end_of_run, end_of_run);
            fails++;
          end
        end
      end
    end
  end

  // Wait out the idle gap, then present the item and hold it until taken
  task automatic send_request(input cyl_t cyl, input logic last, input int gap,
                              input logic typed, input cyl_t t_cyl,
                              input logic [SUM_W-1:0] t_total);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    cylinder     <= cyl;
    last_request <= last;
    typed_on     = typed;
    typed_cyl    = t_cyl;
    typed_total  = t_total;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Drop start, drain every expected result and let the block fall idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (serve_queue.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DC_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DISK_CYLINDERS: disk_cyl = val;
      REG_START_HEAD:     head_cfg = val[CYL_BITS-1:0];
      REG_SWEEP_UP:       sweep_up = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Watchdog: a hang or a lost result ends the run here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int               n_req, gap_max, size_pick;
    cyl_t             cyl, prev_cyl;
    logic [DC_W-1:0]  dc;
    logic [DC_W-1:0]  hd;
    start        = 1'b0;
    cylinder     = '0;
    last_request = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_DISK_CYLINDERS;
    cfg_data     = '0;
    typed_on     = 1'b0;
    typed_cyl    = '0;
    typed_total  = '0;
    disk_cyl     = 17'd200;
    head_cfg     = '0;
    sweep_up     = 1'b1;
    req_cnt      = 0;
    head_pos     = 0;
    move_sum     = 0;
    fails        = 0;
    items_sent   = 0;
    prev_cyl     = '0;
    rst          = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: walk the table; hold writes until the block is idle
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[r].idx, dir_rows[r].value);
      end else begin
        send_request(dir_rows[r].value[CYL_BITS-1:0], dir_rows[r].last,
                     $urandom_range(0, 14), dir_rows[r].typed,
                     dir_rows[r].exp_cyl, dir_rows[r].exp_total);
      end
    end

    // Random part: a fresh setting per phase, then a few batches under it
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       dc = '0;
        1:       dc = 17'd1;
        2:       dc = 17'h10000;
        3:       dc = DC_W'($urandom_range(17'h10001, 17'h1FFFF));
        4:       dc = DC_W'($urandom_range(0, 17'h1FFFF));
        default: dc = DC_W'($urandom_range(2, 400));
      endcase
      case ($urandom_range(0, 7))
        0:       hd = '0;
        1:       hd = 17'd65535;
        2:       hd = DC_W'($urandom_range(0, 65535));
        default: hd = DC_W'($urandom_range(0, (dc > 65535) ? 65535 : dc));
      endcase
      write_reg(REG_DISK_CYLINDERS, dc);
      write_reg(REG_START_HEAD, hd);
      write_reg(REG_SWEEP_UP, DC_W'($urandom_range(0, 1)));
      // A quarter of the phases run back to back with no idling
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      repeat ($urandom_range(2, 5)) begin
        size_pick = $urandom_range(0, 19);
        if (size_pick == 0)      n_req = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 8);
        else if (size_pick < 4)  n_req = $urandom_range(9, MAX_REQUESTS - 1);
        else                     n_req = $urandom_range(1, 8);
        for (int k = 0; k < n_req; k++) begin
          case ($urandom_range(0, 7))
            0:       cyl = cyl_t'($urandom_range(0, 65535));
            1:       cyl = prev_cyl;
            default: cyl = cyl_t'($urandom_range(0, top_cylinder()));
          endcase
          prev_cyl = cyl;
          send_request(cyl, k == n_req - 1, $urandom_range(0, gap_max), 1'b0, '0, '0);
        end
      end
    end

    settle();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
